// ----- design/dll_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_pkg
// Shared widths, opcodes, status codes, FSM states and the controller to
// datapath command/status types of the linked list engine.
// ----------------------------------------------------------------------------
package dll_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OPCODE_W     = 3;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DELETE    = 3'd2,
        OP_SEARCH    = 3'd3,
        OP_DUMP_FWD  = 3'd4,
        OP_DUMP_BWD  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } st_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_WALK,
        S_UNLINK,
        S_FREE,
        S_RESP
    } state_t;

    // one datapath command per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_INSERT,
        DP_FOLLOW,
        DP_MISS,
        DP_FOUND,
        DP_HIT_DELETE,
        DP_UNLINK,
        DP_FREE,
        DP_EMIT_ELEM,
        DP_EMIT_RESP
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;        // opcode of the word in progress
        logic empty;     // list holds no element
        logic match;     // node just read holds the search value
        logic at_last;   // node just read is the last one of the walk
        logic middle;    // node just read has neighbors on both sides
        logic out_free;  // result register can take a word this cycle
    } dp_status_t;

endpackage

// ----- design/dll_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_in_if
// Request channel: valid/ready handshake carrying opcode and value.
// ----------------------------------------------------------------------------
interface dll_in_if;
    import dll_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [DATA_W-1:0]   data_value;

    modport source (output valid, output opcode, output data_value, input ready);
    modport sink   (input valid, input opcode, input data_value, output ready);

endinterface

// ----- design/dll_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_out_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface dll_out_if;
    import dll_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic                       found;
    logic signed [DATA_W-1:0]   element_value;
    logic                       has_value;
    logic                       last;
    logic [COUNT_W-1:0]         count;

    modport source (output valid, output status, output found, output element_value,
                    output has_value, output last, output count, input ready);
    modport sink   (input valid, input status, input found, input element_value,
                    input has_value, input last, input count, output ready);

endinterface

// ----- design/dll_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_datapath
// Node pool memories, list pointers, free list and result register.
// Executes one controller command per cycle.
// ----------------------------------------------------------------------------
module dll_datapath #(
    parameter int CAPACITY = dll_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dll_pkg::dp_cmd_t                  cmd,
    output dll_pkg::dp_status_t               status,
    input  logic [dll_pkg::OPCODE_W-1:0]      in_opcode,
    input  logic signed [dll_pkg::DATA_W-1:0] in_data_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dll_pkg::STATUS_W-1:0]      out_status,
    output logic                              out_found,
    output logic signed [dll_pkg::DATA_W-1:0] out_element_value,
    output logic                              out_has_value,
    output logic                              out_last,
    output logic [dll_pkg::COUNT_W-1:0]       out_count
);
    import dll_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // node pool
    logic signed [DATA_W-1:0] val_mem  [CAPACITY];
    logic [IDX_W-1:0]         next_mem [CAPACITY];
    logic [IDX_W-1:0]         prev_mem [CAPACITY];

    // control registers
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    op_t                      op_reg, op_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]         cur_reg, cur_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    st_t                      st_reg, st_next;
    logic                     found_reg, found_next;
    logic signed [DATA_W-1:0] rd_val_reg;
    logic [IDX_W-1:0]         rd_next_reg;
    logic [IDX_W-1:0]         rd_prev_reg;
    st_t                      o_status_reg, o_status_next;
    logic                     o_found_reg, o_found_next;
    logic signed [DATA_W-1:0] o_value_reg, o_value_next;
    logic                     o_has_reg, o_has_next;
    logic                     o_last_reg, o_last_next;
    logic [COUNT_W-1:0]       o_count_reg, o_count_next;

    // memory ports
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     val_we, next_we, prev_we;
    logic [IDX_W-1:0]         val_wa, next_wa, prev_wa;
    logic signed [DATA_W-1:0] val_wd;
    logic [IDX_W-1:0]         next_wd, prev_wd;

    logic                     full, empty, at_last, out_free;
    logic [IDX_W-1:0]         slot, follow_addr;
    logic [COUNT_W+CNT_W-1:0] cnt_ext;

    assign full        = (cnt_reg == CNT_W'(CAPACITY));
    assign empty       = (cnt_reg == '0);
    assign at_last     = (CNT_W'(pos_reg) == cnt_reg - CNT_W'(1));
    assign out_free    = !out_valid_reg || out_ready;
    // reuse a freed node if any, else the next never-used one
    assign slot        = (free_cnt_reg != '0) ? free_head_reg : fresh_reg[IDX_W-1:0];
    assign follow_addr = (op_reg == OP_DUMP_BWD) ? rd_prev_reg : rd_next_reg;
    assign cnt_ext     = {COUNT_W'(0), cnt_reg};

    assign status.op       = op_reg;
    assign status.empty    = empty;
    assign status.match    = (rd_val_reg == val_reg);
    assign status.at_last  = at_last;
    assign status.middle   = !(cnt_reg == CNT_W'(1)) && (pos_reg != '0) && !at_last;
    assign status.out_free = out_free;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        free_head_next = free_head_reg;
        free_cnt_next  = free_cnt_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        st_next        = st_reg;
        found_next     = found_reg;
        o_status_next  = o_status_reg;
        o_found_next   = o_found_reg;
        o_value_next   = o_value_reg;
        o_has_next     = o_has_reg;
        o_last_next    = o_last_reg;
        o_count_next   = o_count_reg;
        rd_en          = 1'b0;
        rd_addr        = cur_reg;
        val_we         = 1'b0;
        val_wa         = slot;
        val_wd         = val_reg;
        next_we        = 1'b0;
        next_wa        = slot;
        next_wd        = head_reg;
        prev_we        = 1'b0;
        prev_wa        = slot;
        prev_wd        = tail_reg;

        case (cmd)
            DP_ACCEPT:
            begin
                op_next    = op_t'(in_opcode);
                val_next   = in_data_value;
                pos_next   = '0;
                found_next = 1'b0;
                st_next    = (op_t'(in_opcode) == OP_DELETE && empty) ? ST_NOT_FOUND : ST_OK;
                rd_en      = 1'b1;
                case (op_t'(in_opcode))
                    OP_INS_FRONT, OP_INS_BACK: rd_addr = free_head_reg;
                    OP_DUMP_BWD:               rd_addr = tail_reg;
                    default:                   rd_addr = head_reg;
                endcase
                cur_next = rd_addr;
            end
            DP_INSERT:
            begin
                if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    val_we = 1'b1;
                    if (op_reg == OP_INS_FRONT)
                    begin
                        next_we = 1'b1;
                        next_wd = head_reg;
                        prev_we = !empty;
                        prev_wa = head_reg;
                        prev_wd = slot;
                        head_next = slot;
                        if (empty)
                        begin
                            tail_next = slot;
                        end
                    end
                    else
                    begin
                        prev_we = 1'b1;
                        prev_wd = tail_reg;
                        next_we = !empty;
                        next_wa = tail_reg;
                        next_wd = slot;
                        tail_next = slot;
                        if (empty)
                        begin
                            head_next = slot;
                        end
                    end
                    if (free_cnt_reg != '0)
                    begin
                        // rd_next_reg holds the link of the free list head
                        free_head_next = rd_next_reg;
                        free_cnt_next  = free_cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        fresh_next = fresh_reg + CNT_W'(1);
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            DP_FOLLOW:
            begin
                rd_en    = 1'b1;
                rd_addr  = follow_addr;
                cur_next = follow_addr;
                pos_next = pos_reg + IDX_W'(1);
            end
            DP_MISS:
            begin
                st_next = ST_NOT_FOUND;
            end
            DP_FOUND:
            begin
                found_next = 1'b1;
            end
            DP_HIT_DELETE:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (pos_reg == '0)
                begin
                    head_next = rd_next_reg;
                end
                else if (at_last)
                begin
                    tail_next = rd_prev_reg;
                end
            end
            DP_UNLINK:
            begin
                next_we = 1'b1;
                next_wa = rd_prev_reg;
                next_wd = rd_next_reg;
                prev_we = 1'b1;
                prev_wa = rd_next_reg;
                prev_wd = rd_prev_reg;
            end
            DP_FREE:
            begin
                // push the node onto the free list
                next_we        = 1'b1;
                next_wa        = cur_reg;
                next_wd        = free_head_reg;
                free_head_next = cur_reg;
                free_cnt_next  = free_cnt_reg + CNT_W'(1);
                cnt_next       = cnt_reg - CNT_W'(1);
            end
            DP_EMIT_ELEM:
            begin
                out_valid_next = 1'b1;
                o_status_next  = ST_OK;
                o_found_next   = 1'b0;
                o_value_next   = rd_val_reg;
                o_has_next     = 1'b1;
                o_last_next    = at_last;
                o_count_next   = cnt_ext[COUNT_W-1:0];
                if (!at_last)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = follow_addr;
                    cur_next = follow_addr;
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            DP_EMIT_RESP:
            begin
                out_valid_next = 1'b1;
                o_status_next  = st_reg;
                o_found_next   = found_reg;
                o_value_next   = '0;
                o_has_next     = 1'b0;
                o_last_next    = 1'b1;
                o_count_next   = cnt_ext[COUNT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            free_head_reg <= '0;
            free_cnt_reg  <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        st_reg       <= st_next;
        found_reg    <= found_next;
        o_status_reg <= o_status_next;
        o_found_reg  <= o_found_next;
        o_value_reg  <= o_value_next;
        o_has_reg    <= o_has_next;
        o_last_reg   <= o_last_next;
        o_count_reg  <= o_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_wa] <= val_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (rd_en)
        begin
            rd_val_reg  <= val_mem[rd_addr];
            rd_next_reg <= next_mem[rd_addr];
            rd_prev_reg <= prev_mem[rd_addr];
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = o_status_reg;
    assign out_found         = o_found_reg;
    assign out_element_value = o_value_reg;
    assign out_has_value     = o_has_reg;
    assign out_last          = o_last_reg;
    // count is captured with the word so a later request cannot change it
    assign out_count         = o_count_reg;

endmodule

// ----- design/dll_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_ctrl
// Sequencer of the list engine: decodes a request word and steps the
// datapath through insert, walk, unlink and free phases.
// ----------------------------------------------------------------------------
module dll_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [dll_pkg::OPCODE_W-1:0] in_opcode,
    output logic                         in_ready,
    input  dll_pkg::dp_status_t          status,
    output dll_pkg::dp_cmd_t             cmd
);
    import dll_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_opcode inside {OP_INS_FRONT, OP_INS_BACK})
                    begin
                        state_next = S_INSERT;
                    end
                    else if (in_opcode inside {OP_DELETE, OP_SEARCH, OP_DUMP_FWD, OP_DUMP_BWD})
                    begin
                        state_next = status.empty ? S_RESP : S_WALK;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_INSERT:
            begin
                state_next = S_RESP;
            end
            S_WALK:
            begin
                case (status.op)
                    OP_SEARCH:
                    begin
                        if (status.match || status.at_last)
                        begin
                            state_next = S_RESP;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (status.match)
                        begin
                            state_next = status.middle ? S_UNLINK : S_FREE;
                        end
                        else if (status.at_last)
                        begin
                            state_next = S_RESP;
                        end
                    end
                    OP_DUMP_FWD, OP_DUMP_BWD:
                    begin
                        if (status.out_free && status.at_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_UNLINK:
            begin
                state_next = S_FREE;
            end
            S_FREE:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = DP_ACCEPT;
                end
            end
            S_INSERT:
            begin
                cmd = DP_INSERT;
            end
            S_WALK:
            begin
                case (status.op)
                    OP_SEARCH:
                    begin
                        if (status.match)
                        begin
                            cmd = DP_FOUND;
                        end
                        else if (!status.at_last)
                        begin
                            cmd = DP_FOLLOW;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (status.match)
                        begin
                            cmd = DP_HIT_DELETE;
                        end
                        else if (status.at_last)
                        begin
                            cmd = DP_MISS;
                        end
                        else
                        begin
                            cmd = DP_FOLLOW;
                        end
                    end
                    OP_DUMP_FWD, OP_DUMP_BWD:
                    begin
                        if (status.out_free)
                        begin
                            cmd = DP_EMIT_ELEM;
                        end
                    end
                    default:
                    begin
                        cmd = DP_NOP;
                    end
                endcase
            end
            S_UNLINK:
            begin
                cmd = DP_UNLINK;
            end
            S_FREE:
            begin
                cmd = DP_FREE;
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd = DP_EMIT_RESP;
                end
            end
            default:
            begin
                cmd = DP_NOP;
            end
        endcase
    end

endmodule

// ----- design/doubly_linked_list_engine_core.sv -----
`timescale 1ns / 1ps
// From accept: a no-op, or search/delete/dump on an empty list, goes straight
// to the response; insert passes S_INSERT first; search and delete walk nodes
// one per cycle, a delete hit then passing S_UNLINK (mid-list) and S_FREE; a
// dump gives one word per cycle while output is free; one request word at a time.
// Reset: rst_n async, clears pointers, counts and FSM; node memories are
// left uninitialized and need no clearing pass.
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_core
// Bounded doubly linked list in a node pool with insert, delete, search and
// forward/backward read-out.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_core #(
    parameter int CAPACITY = dll_pkg::CAPACITY_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    dll_in_if.sink   req,
    dll_out_if.source rsp
);
    import dll_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    dll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dll_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_opcode         (req.opcode),
        .in_data_value     (req.data_value),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_status        (rsp.status),
        .out_found         (rsp.found),
        .out_element_value (rsp.element_value),
        .out_has_value     (rsp.has_value),
        .out_last          (rsp.last),
        .out_count         (rsp.count)
    );

    assign req.ready = in_ready;

    // one request in flight: no accept right after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted back to back");

    // a dropped insert is a single word with no element
    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FULL) |-> rsp.last && !rsp.has_value && !rsp.found)
        else $error("full status on a non-terminal or element word");

    // element words only come from dumps
    a_elem_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.has_value |-> (rsp.status == ST_OK) && !rsp.found)
        else $error("element word with status or found set");

endmodule
